### hw/rtl/sckl_pkg.sv
// shared types, constants and helpers for the substitution cipher core
// no dependencies; imported by every module of the block
`default_nettype none

package sckl_pkg;

    localparam int ALPHABET_SIZE = 33;
    localparam int COUNT_WIDTH   = 16;
    localparam int CP_W          = 21;
    localparam int OFF_W         = $clog2(ALPHABET_SIZE);
    localparam int POS_W         = $clog2(ALPHABET_SIZE + 1);
    localparam int STATUS_W      = 3;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = CP_W;

    localparam logic [POS_W-1:0] SPECIAL_POS  = POS_W'(6);
    localparam logic [OFF_W-1:0] SPECIAL_SLOT = OFF_W'(ALPHABET_SIZE - 1);
    localparam logic [POS_W-1:0] LOAD_DONE    = POS_W'(ALPHABET_SIZE);
    localparam logic [CP_W-1:0]  BASE_RESET   = CP_W'(1072);
    localparam logic [COUNT_WIDTH-1:0] KEPT_MAX = {COUNT_WIDTH{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 1'd1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_KEY_DONE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_KEY_RANGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_KEY_DUP   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NO_KEY    = 3'd6;

    typedef struct packed {
        logic            kind;
        logic            first;
        logic            last;
        logic [CP_W-1:0] code_point;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [CP_W-1:0]        out_code_point;
        logic [COUNT_WIDTH-1:0] kept_count;
        logic                   message_end;
    } t_out_item;

    // result of the table step, before the final add
    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [COUNT_WIDTH-1:0] kept;
        logic                   message_end;
        logic                   hit;
    } t_mid_item;

    typedef struct packed {
        logic             en;
        logic [OFF_W-1:0] addr;
        logic [OFF_W-1:0] data;
    } t_tbl_wr;

    typedef struct packed {
        logic             en;
        logic [OFF_W-1:0] addr;
    } t_tbl_rd;

    // load position to table slot: position 6 goes to the last slot
    function automatic logic [OFF_W-1:0] slot_of(input logic [POS_W-1:0] pos);
        logic [OFF_W-1:0] slot;
        if (pos == SPECIAL_POS) begin
            slot = SPECIAL_SLOT;
        end else if (pos > SPECIAL_POS) begin
            slot = OFF_W'(pos - POS_W'(1));
        end else begin
            slot = OFF_W'(pos);
        end
        return slot;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/sckl_key_mem.sv
// key table storage: one write port, one registered read port
// depends on sckl_pkg
`default_nettype none

module sckl_key_mem (
    input  wire                      i_clk,
    input  sckl_pkg::t_tbl_wr        i_wr,
    input  sckl_pkg::t_tbl_rd        i_rd,
    output logic [sckl_pkg::OFF_W-1:0] o_rd_data
);
    import sckl_pkg::*;

    logic [OFF_W-1:0] r_mem [ALPHABET_SIZE];
    logic [OFF_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hw/rtl/sckl_step.sv
// per-symbol step: key load state, range and duplicate checks, kept count
// depends on sckl_pkg and sckl_key_mem
`default_nettype none

module sckl_step (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_adv,
    input  sckl_pkg::t_in_item         i_item,
    input  wire                        i_inverse,
    input  wire [sckl_pkg::CP_W-1:0]   i_base,
    output sckl_pkg::t_mid_item        o_mid,
    output logic [sckl_pkg::OFF_W-1:0] o_rd_data
);
    import sckl_pkg::*;

    logic [ALPHABET_SIZE-1:0] r_seen,   n_seen;
    logic [POS_W-1:0]         r_pos,    n_pos;
    logic                     r_valid,  n_valid;
    logic                     r_failed, n_failed;
    logic                     r_inv,    n_inv;
    logic [COUNT_WIDTH-1:0]   r_kept,   n_kept;
    t_mid_item                r_mid,    n_mid;

    logic [CP_W:0]    diff;
    logic             in_range;
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] slot;
    t_tbl_wr          tbl_wr;
    t_tbl_rd          tbl_rd;

    // offset inside the alphabet, borrow bit flags code points below base
    assign diff     = {1'b0, i_item.code_point} - {1'b0, i_base};
    assign in_range = !diff[CP_W] && (diff[CP_W-1:0] < CP_W'(ALPHABET_SIZE));
    assign off      = diff[OFF_W-1:0];

    always_comb begin
        n_seen   = r_seen;
        n_pos    = r_pos;
        n_valid  = r_valid;
        n_failed = r_failed;
        n_inv    = r_inv;
        n_kept   = r_kept;
        n_mid    = '0;
        tbl_wr   = '0;
        tbl_rd   = '0;
        slot     = '0;
        if (!i_item.kind) begin
            n_mid.kept = r_kept;
            if (i_item.first) begin
                n_seen   = '0;
                n_pos    = '0;
                n_valid  = 1'b0;
                n_failed = 1'b0;
            end
            if (!i_item.first && (r_failed || (r_pos >= LOAD_DONE))) begin
                n_mid.status = ST_IGNORED;
            end else begin
                if (n_pos == '0) begin
                    n_inv = i_inverse;
                end
                n_valid = 1'b0;
                if (!in_range) begin
                    n_failed     = 1'b1;
                    n_mid.status = ST_KEY_RANGE;
                end else if (n_seen[off]) begin
                    n_failed     = 1'b1;
                    n_mid.status = ST_KEY_DUP;
                end else begin
                    // slot of the current load position, before it moves on
                    slot        = slot_of(n_pos);
                    n_seen[off] = 1'b1;
                    tbl_wr.en   = 1'b1;
                    tbl_wr.addr = n_inv ? off : slot;
                    tbl_wr.data = n_inv ? slot : off;
                    n_pos       = n_pos + POS_W'(1);
                    if (n_pos == LOAD_DONE) begin
                        n_valid      = 1'b1;
                        n_mid.status = ST_KEY_DONE;
                    end else begin
                        n_mid.status = ST_OK;
                    end
                end
            end
        end else begin
            if (!r_valid) begin
                n_mid.status = ST_NO_KEY;
            end else if (in_range) begin
                n_mid.status = ST_OK;
                n_mid.hit    = 1'b1;
                tbl_rd.en    = 1'b1;
                tbl_rd.addr  = off;
                if (r_kept != KEPT_MAX) begin
                    n_kept = r_kept + COUNT_WIDTH'(1);
                end
            end else begin
                n_mid.status = ST_DROPPED;
            end
            n_mid.kept        = n_kept;
            n_mid.message_end = i_item.last;
            if (i_item.last) begin
                n_kept = '0;
            end
        end
        if (!i_adv) begin
            tbl_wr.en = 1'b0;
            tbl_rd.en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen   <= '0;
            r_pos    <= '0;
            r_valid  <= 1'b0;
            r_failed <= 1'b0;
            r_inv    <= 1'b0;
            r_kept   <= '0;
        end else if (i_adv) begin
            r_seen   <= n_seen;
            r_pos    <= n_pos;
            r_valid  <= n_valid;
            r_failed <= n_failed;
            r_inv    <= n_inv;
            r_kept   <= n_kept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mid <= n_mid;
        end
    end

    sckl_key_mem u_key_mem (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd      (tbl_rd),
        .o_rd_data (o_rd_data)
    );

    assign o_mid = r_mid;

endmodule

`default_nettype wire

### hw/rtl/substitution_cipher_with_key_load_core.sv
// top level of the substitution cipher core: input register, key step, result register
// depends on sckl_pkg, sckl_step and sckl_key_mem
`default_nettype none

// Substitution over a 33-symbol alphabet starting at a programmable base code point.
// Key symbols (kind 0) stream in one per transfer, a transfer with first set starting a
// new load; data symbols (kind 1) inside the alphabet come back substituted once a key
// is loaded, others are dropped. Every input transfer gives exactly one result transfer.
// The core is a three-stage pipeline (input register, table step with its registered key
// memory read, result register with the base add) and takes one transfer per cycle unless
// the input is stalled; an item moves from the input register through the table step to
// the result register. Up to three items are in flight; the input stalls only when all
// three stages are full and the result is stalled. The single key memory write and read
// port in the table step sets that rate. Configuration writes are meant for idle periods.
module substitution_cipher_with_key_load_core (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // configuration
    input  wire                             i_cfg_we,
    input  wire [sckl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [sckl_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // input channel
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  sckl_pkg::t_in_item              i_in_item,
    // result channel
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output sckl_pkg::t_out_item             o_out_item
);
    import sckl_pkg::*;

    // configuration registers
    logic            r_inverse;
    logic [CP_W-1:0] r_base;

    // pipeline stage valids and payloads
    logic         r_a_valid;
    t_in_item     r_a_item;
    logic         r_b_valid;
    logic         r_c_valid;
    t_out_item    r_c_item;
    t_out_item    n_c_item;

    logic             a_ready;
    logic             b_ready;
    logic             c_ready;
    logic             in_xfer;
    logic             a_adv;
    logic             b_adv;
    t_mid_item        mid;
    logic [OFF_W-1:0] rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inverse <= 1'b0;
            r_base    <= BASE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INVERSE: begin
                    r_inverse <= i_cfg_wdata[0];
                end
                CFG_BASE: begin
                    r_base <= i_cfg_wdata[CP_W-1:0];
                end
                default: begin
                    r_base <= r_base;
                end
            endcase
        end
    end

    // a stage can take new work when empty or when its content moves on
    assign c_ready    = !r_c_valid || !i_out_stall;
    assign b_ready    = !r_b_valid || c_ready;
    assign a_ready    = !r_a_valid || b_ready;
    assign o_in_stall = !a_ready;
    assign in_xfer    = i_in_valid && a_ready;
    assign a_adv      = r_a_valid && b_ready;
    assign b_adv      = r_b_valid && c_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a_item <= i_in_item;
        end
    end

    // key load and lookup, state updated as an item leaves the input register
    sckl_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (a_adv),
        .i_item    (r_a_item),
        .i_inverse (r_inverse),
        .i_base    (r_base),
        .o_mid     (mid),
        .o_rd_data (rd_data)
    );

    // result: substituted code point only on a data hit, wrapped to code point width
    always_comb begin
        n_c_item.status         = mid.status;
        n_c_item.kept_count     = mid.kept;
        n_c_item.message_end    = mid.message_end;
        n_c_item.out_code_point = mid.hit ? (r_base + CP_W'(rd_data)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_c_item <= n_c_item;
        end
    end

    assign o_out_valid = r_c_valid;
    assign o_out_item  = r_c_item;

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // the core only stalls its input when the input register holds an item
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_a_valid)
        else $error("input stalled with empty input register");

    // status codes stay within the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status <= ST_NO_KEY))
        else $error("undefined status code");

    // only a successful data lookup carries a code point
    a_cp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != ST_OK) |-> (o_out_item.out_code_point == '0))
        else $error("code point on a non-substituted result");

    // key results never mark a message end
    a_key_no_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_item.status == ST_KEY_DONE) ||
                        (o_out_item.status == ST_KEY_RANGE) ||
                        (o_out_item.status == ST_KEY_DUP) ||
                        (o_out_item.status == ST_IGNORED)) |-> !o_out_item.message_end)
        else $error("message end on a key result");

endmodule

`default_nettype wire
